[design/rpm_pkg.sv]
// Shared types and constants for the rotated pattern match block.
package rpm_pkg;

    localparam int CELL_BITS  = 8;
    localparam int COUNT_BITS = 7;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 7'd127;

    // item kinds
    localparam logic [2:0] K_LOAD  = 3'd0;
    localparam logic [2:0] K_HLITE = 3'd1;
    localparam logic [2:0] K_OBS   = 3'd2;
    localparam logic [2:0] K_TICK  = 3'd3;
    localparam logic [2:0] K_QUERY = 3'd4;

    // register indexes
    localparam logic [1:0] REG_HOLD     = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_MCOUNT   = 2'd2;

    localparam logic [7:0] HOLD_RST     = 8'd20;
    localparam logic [5:0] MISMATCH_RST = 6'd1;
    localparam logic [3:0] MCOUNT_RST   = 4'd6;

    localparam logic REPLY_MATCH = 1'b0;
    localparam logic REPLY_QUERY = 1'b1;

    typedef struct packed {
        logic wr_byte;  // write one pattern byte
        logic clr;      // zero a whole row
        logic rd;       // read a whole row
    } t_mem_cmd;

    typedef struct packed {
        logic upd;      // compare a row against the observed cell
        logic clr;      // zero all counts
    } t_cnt_cmd;

    typedef struct packed {
        logic set_hl;
        logic hl_val;
        logic tick;
        logic match_wr;
    } t_tbl_cmd;

    typedef struct packed {
        logic present;
        logic highlighted;
        logic in_rect;
    } t_tbl_stat;

endpackage

[design/rpm_ref_mem.sv]
// Reference pattern memory: one row per cell, one byte lane per stored pattern.
module rpm_ref_mem #(
    parameter int PATTERNS = 32,
    parameter int CELLS    = 64
) (
    input  logic                                 i_clk,
    input  rpm_pkg::t_mem_cmd                    i_cmd,
    input  logic [$clog2(CELLS)-1:0]             i_row,
    input  logic [$clog2(PATTERNS)-1:0]          i_lane,
    input  logic [rpm_pkg::CELL_BITS-1:0]        i_data,
    output logic [PATTERNS*rpm_pkg::CELL_BITS-1:0] o_rd_data
);
    import rpm_pkg::*;

    logic [PATTERNS*CELL_BITS-1:0] r_mem [CELLS];
    logic [PATTERNS*CELL_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[i_row] <= '0;
        end else if (i_cmd.wr_byte) begin
            r_mem[i_row][i_lane*CELL_BITS +: CELL_BITS] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[i_row];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/rpm_count_bank.sv]
// Per-pattern mismatch counters with the match test for one marker.
module rpm_count_bank #(
    parameter int MAX_MARKERS = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  rpm_pkg::t_cnt_cmd                          i_cmd,
    input  logic [MAX_MARKERS*4*rpm_pkg::CELL_BITS-1:0] i_row,
    input  logic [rpm_pkg::CELL_BITS-1:0]              i_value,
    input  logic [5:0]                                 i_max_mismatch,
    input  logic [((MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1)-1:0] i_idx,
    output logic                                       o_hit
);
    import rpm_pkg::*;

    logic [COUNT_BITS-1:0] r_cnt [MAX_MARKERS][4];
    logic [COUNT_BITS-1:0] n_cnt [MAX_MARKERS][4];

    always_comb begin
        for (int m = 0; m < MAX_MARKERS; m++) begin
            for (int r = 0; r < 4; r++) begin
                n_cnt[m][r] = r_cnt[m][r];
                if (i_cmd.clr) begin
                    n_cnt[m][r] = '0;
                end else if (i_cmd.upd &&
                             i_row[(m*4+r)*CELL_BITS +: CELL_BITS] != i_value &&
                             r_cnt[m][r] != COUNT_MAX) begin
                    n_cnt[m][r] = r_cnt[m][r] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MAX_MARKERS; m++) begin
                for (int r = 0; r < 4; r++) begin
                    r_cnt[m][r] <= '0;
                end
            end
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_comb begin
        o_hit = 1'b0;
        for (int r = 0; r < 4; r++) begin
            if (r_cnt[i_idx][r] <= {1'b0, i_max_mismatch}) begin
                o_hit = 1'b1;
            end
        end
    end

endmodule

[design/rpm_marker_table.sv]
// Per-marker presence counters, highlight flags and stored rectangles.
module rpm_marker_table #(
    parameter int MAX_MARKERS = 8,
    parameter int COORD_BITS  = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rpm_pkg::t_tbl_cmd       i_cmd,
    input  logic [2:0]              i_hl_marker,
    input  logic [((MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1)-1:0] i_idx,
    input  logic [7:0]              i_hold,
    input  logic [COORD_BITS-1:0]   i_left,
    input  logic [COORD_BITS-1:0]   i_top,
    input  logic [COORD_BITS-1:0]   i_right,
    input  logic [COORD_BITS-1:0]   i_bottom,
    output rpm_pkg::t_tbl_stat      o_stat
);
    import rpm_pkg::*;

    logic [7:0]            r_presence [MAX_MARKERS];
    logic                  r_hl       [MAX_MARKERS];
    logic [COORD_BITS-1:0] r_left     [MAX_MARKERS];
    logic [COORD_BITS-1:0] r_top      [MAX_MARKERS];
    logic [COORD_BITS-1:0] r_right    [MAX_MARKERS];
    logic [COORD_BITS-1:0] r_bottom   [MAX_MARKERS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MAX_MARKERS; m++) begin
                r_presence[m] <= '0;
                r_hl[m]       <= 1'b0;
                r_left[m]     <= '0;
                r_top[m]      <= '0;
                r_right[m]    <= '0;
                r_bottom[m]   <= '0;
            end
        end else begin
            for (int m = 0; m < MAX_MARKERS; m++) begin
                if (i_cmd.tick && r_presence[m] != 8'd0) begin
                    r_presence[m] <= r_presence[m] - 8'd1;
                end
                if (i_cmd.set_hl && 32'(i_hl_marker) == m) begin
                    r_hl[m] <= i_cmd.hl_val;
                end
                if (i_cmd.match_wr && 32'(i_idx) == m) begin
                    r_presence[m] <= i_hold;
                    if (r_hl[m]) begin
                        r_left[m]   <= i_left;
                        r_top[m]    <= i_top;
                        r_right[m]  <= i_right;
                        r_bottom[m] <= i_bottom;
                    end
                end
            end
        end
    end

    // i_left/i_top double as the query point during a query scan
    always_comb begin
        o_stat.present     = r_presence[i_idx] != 8'd0;
        o_stat.highlighted = r_hl[i_idx];
        o_stat.in_rect     = i_left >= r_left[i_idx] && i_left <= r_right[i_idx] &&
                             i_top >= r_top[i_idx] && i_top <= r_bottom[i_idx];
    end

endmodule

[design/rotated_pattern_match_table_unit.sv]
// Top level: item sequencer, configuration registers and result register.
// Stores four rotated reference patterns per marker in a cell-indexed memory
// whose row holds one byte per pattern, so each observed cell is compared
// against every pattern at once. After reset a clearing pass zeroes the
// memory, one row a cycle; no item is taken meanwhile. Load, highlight,
// tick and unused kinds are handled in the idle state when taken. An
// observed cell passes through the memory row read and then the mismatch
// counter update. The last cell, and a point query, then add a scan of one
// marker per cycle over markers below min(marker_count, MAX_MARKERS),
// stopping at the first hit, before the answer enters the output register.
// The scan holds while that register is full and not being taken.
module rotated_pattern_match_table_unit #(
    parameter int MAX_MARKERS = 8,
    parameter int CELLS       = 64,
    parameter int COORD_BITS  = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_kind,
    input  logic [2:0]            i_marker_index,
    input  logic [1:0]            i_rotation,
    input  logic [5:0]            i_cell_index,
    input  logic [7:0]            i_cell_value,
    input  logic                  i_last_cell,
    input  logic                  i_highlight,
    input  logic [COORD_BITS-1:0] i_x_coord,
    input  logic [COORD_BITS-1:0] i_y_coord,
    input  logic [COORD_BITS-1:0] i_right_coord,
    input  logic [COORD_BITS-1:0] i_bottom_coord,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_reply_kind,
    output logic                  o_found,
    output logic [2:0]            o_found_marker,
    output logic                  o_newly_detected,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import rpm_pkg::*;

    localparam int PATTERNS = MAX_MARKERS * 4;
    localparam int RW   = $clog2(CELLS);
    localparam int LW   = $clog2(PATTERNS);
    localparam int MKW  = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
    localparam int IDXW = $clog2(MAX_MARKERS + 1);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_MSCAN = 3'd3;
    localparam logic [2:0] S_QSCAN = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [RW-1:0]         r_clr_row;
    logic [IDXW-1:0]       r_idx, n_idx;
    logic [7:0]            r_hold;
    logic [5:0]            r_max_mismatch;
    logic [3:0]            r_marker_count;
    logic                  r_cell_ok;
    logic                  r_last;
    logic [7:0]            r_obs_val;
    logic [COORD_BITS-1:0] r_x, r_y, r_r, r_b;
    logic                  r_out_valid;
    logic                  r_out_kind, r_out_found, r_out_new;
    logic [2:0]            r_out_marker;

    logic                  w_accept, w_out_free, w_cell_in, w_mk_in, w_load_out;
    logic                  w_l_kind, w_l_found, w_l_new;
    logic [IDXW-1:0]       w_n;
    logic                  w_scan_end;
    t_mem_cmd              w_mem_cmd;
    t_cnt_cmd              w_cnt_cmd;
    t_tbl_cmd              w_tbl_cmd;
    t_tbl_stat             w_stat;
    logic [RW-1:0]         w_row;
    logic [LW-1:0]         w_lane;
    logic [PATTERNS*CELL_BITS-1:0] w_rd_row;
    logic                  w_hit;
    logic                  w_cfg_wr;

    assign o_ready    = r_state == S_IDLE;
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_cell_in  = 32'(i_cell_index) < CELLS;
    assign w_mk_in    = 32'(i_marker_index) < MAX_MARKERS;
    assign w_n        = (32'(r_marker_count) > MAX_MARKERS) ? IDXW'(MAX_MARKERS)
                                                            : IDXW'(r_marker_count);
    assign w_scan_end = r_idx >= w_n;
    assign w_row      = (r_state == S_CLR) ? r_clr_row : RW'(i_cell_index);
    assign w_lane     = LW'({i_marker_index, i_rotation});

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_HOLD:     prdata = {24'd0, r_hold};
            REG_MISMATCH: prdata = {26'd0, r_max_mismatch};
            REG_MCOUNT:   prdata = {28'd0, r_marker_count};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold         <= HOLD_RST;
            r_max_mismatch <= MISMATCH_RST;
            r_marker_count <= MCOUNT_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_HOLD:     r_hold         <= pwdata[7:0];
                REG_MISMATCH: r_max_mismatch <= pwdata[5:0];
                REG_MCOUNT:   r_marker_count <= pwdata[3:0];
                default:      ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        w_mem_cmd  = '0;
        w_cnt_cmd  = '0;
        w_tbl_cmd  = '0;
        w_tbl_cmd.hl_val = i_highlight;
        w_load_out = 1'b0;
        w_l_kind   = REPLY_MATCH;
        w_l_found  = 1'b0;
        w_l_new    = 1'b0;
        case (r_state)
            S_CLR: begin
                w_mem_cmd.clr = 1'b1;
                if (r_clr_row == RW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_idx = '0;
                    case (i_kind)
                        K_LOAD:  w_mem_cmd.wr_byte = w_mk_in && w_cell_in;
                        K_HLITE: w_tbl_cmd.set_hl  = w_mk_in;
                        K_OBS: begin
                            w_mem_cmd.rd = w_cell_in;
                            n_state      = S_CMP;
                        end
                        K_TICK:  w_tbl_cmd.tick = 1'b1;
                        K_QUERY: n_state = S_QSCAN;
                        default: ;
                    endcase
                end
            end
            S_CMP: begin
                w_cnt_cmd.upd = r_cell_ok;
                n_state       = r_last ? S_MSCAN : S_IDLE;
            end
            S_MSCAN: begin
                if (w_out_free) begin
                    if (w_scan_end) begin
                        w_load_out    = 1'b1;
                        w_cnt_cmd.clr = 1'b1;
                        n_state       = S_IDLE;
                    end else if (w_hit) begin
                        w_load_out         = 1'b1;
                        w_l_found          = 1'b1;
                        w_l_new            = !w_stat.present && w_stat.highlighted;
                        w_tbl_cmd.match_wr = 1'b1;
                        w_cnt_cmd.clr      = 1'b1;
                        n_state            = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_QSCAN: begin
                w_l_kind = REPLY_QUERY;
                if (w_out_free) begin
                    if (w_scan_end) begin
                        w_load_out = 1'b1;
                        n_state    = S_IDLE;
                    end else if (w_stat.present && w_stat.in_rect) begin
                        w_load_out = 1'b1;
                        w_l_found  = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_row   <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (r_state == S_CLR) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item word and result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cell_ok <= w_cell_in;
            r_last    <= i_last_cell;
            r_obs_val <= i_cell_value;
            r_x       <= i_x_coord;
            r_y       <= i_y_coord;
            r_r       <= i_right_coord;
            r_b       <= i_bottom_coord;
        end
        if (w_load_out) begin
            r_out_kind   <= w_l_kind;
            r_out_found  <= w_l_found;
            r_out_marker <= w_l_found ? 3'(r_idx) : 3'd0;
            r_out_new    <= w_l_new;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_reply_kind     = r_out_kind;
    assign o_found          = r_out_found;
    assign o_found_marker   = r_out_marker;
    assign o_newly_detected = r_out_new;

    rpm_ref_mem #(
        .PATTERNS (PATTERNS),
        .CELLS    (CELLS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_cmd     (w_mem_cmd),
        .i_row     (w_row),
        .i_lane    (w_lane),
        .i_data    (i_cell_value),
        .o_rd_data (w_rd_row)
    );

    rpm_count_bank #(
        .MAX_MARKERS (MAX_MARKERS)
    ) u_cnt (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cnt_cmd),
        .i_row          (w_rd_row),
        .i_value        (r_obs_val),
        .i_max_mismatch (r_max_mismatch),
        .i_idx          (r_idx[MKW-1:0]),
        .o_hit          (w_hit)
    );

    rpm_marker_table #(
        .MAX_MARKERS (MAX_MARKERS),
        .COORD_BITS  (COORD_BITS)
    ) u_tbl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_tbl_cmd),
        .i_hl_marker (i_marker_index),
        .i_idx       (r_idx[MKW-1:0]),
        .i_hold      (r_hold),
        .i_left      (r_x),
        .i_top       (r_y),
        .i_right     (r_r),
        .i_bottom    (r_b),
        .o_stat      (w_stat)
    );

endmodule
